@@ rtl/core/sacl_pkg.sv @@
// Shared constants for the set-associative cache: request codes, status codes
// and the default geometry. No dependencies.
package sacl_pkg;

  localparam int SETS_DEF       = 16;
  localparam int LINE_BYTES_DEF = 64;
  localparam int ADDR_BITS_DEF  = 17;
  localparam int WAYS           = 4;

  localparam logic [2:0] ACT_READ     = 3'd0;
  localparam logic [2:0] ACT_WRITE    = 3'd1;
  localparam logic [2:0] ACT_FLUSH    = 3'd2;
  localparam logic [2:0] ACT_PRELOAD  = 3'd3;
  localparam logic [2:0] ACT_READBACK = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_CROSS = 2'd2;

endpackage

@@ rtl/core/set_assoc_cache_lru_plru_top.sv @@
// Four-way write-back cache with LRU / tree pseudo-LRU replacement and its
// backing byte memory. Depends on sacl_pkg.
//
// Usage: requests enter on in_valid/in_ready, one at a time; each request
// yields exactly one result on out_valid/out_ready. The replacement policy is
// set by cfg_write_en/cfg_data (1 = true LRU, the reset value).
// Paths: a cached hit reads the line data and writes the tag entry, with a
// second data write for a store that spans two words; a miss writes back a
// dirty victim, fills the line from the backing memory and then goes on as
// a hit; preload, bad size and cross go straight to the result; readback
// reads one byte of the backing memory; flush walks every way of every set
// and writes back each dirty line.
// Line transfers move one 32-bit word a cycle through the single write port
// of the backing memory and of the line data memory; that sets the miss cost.
// After reset the block clears the backing memory and the tag memory, one
// word a cycle, all 2^ADDR_BITS/4 words (32768 by default); in_ready stays
// low meanwhile. A result that is not taken holds the block in its final
// step; in_ready rises again only when the result register is loaded.
module set_assoc_cache_lru_plru_top import sacl_pkg::*; #(
  parameter int SETS       = SETS_DEF,
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           action,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [31:0]          store_data,
  input  logic [2:0]           size_bytes,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          read_data,
  output logic                 hit,
  output logic [1:0]           result_way,
  output logic                 wrote_back,
  output logic [1:0]           status
);

  localparam int OFF_W     = $clog2(LINE_BYTES);
  localparam int SET_L     = $clog2(SETS);
  localparam int SET_W     = (SET_L > 0) ? SET_L : 1;
  localparam int TAG_W     = ADDR_BITS - OFF_W - SET_L;
  localparam int WPL       = LINE_BYTES / 4;
  localparam int WI_W      = (WPL > 1) ? $clog2(WPL) : 1;
  localparam int CNT_W     = $clog2(WPL + 1);
  localparam int MEM_WORDS = (1 << ADDR_BITS) / 4;
  localparam int MA_W      = ADDR_BITS - 2;
  localparam int DA_W      = $clog2(SETS * WAYS * WPL);

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0]             dirty;
    logic [WAYS-1:0][TAG_W-1:0]  tag;
    logic [WAYS-1:0][31:0]       stamp;
    logic [2:0]                  tree;
  } meta_t;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_WB    = 4'd3;
  localparam logic [3:0] S_FILL  = 4'd4;
  localparam logic [3:0] S_RD0   = 4'd5;
  localparam logic [3:0] S_RD1   = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_WR1   = 4'd8;
  localparam logic [3:0] S_RBK   = 4'd9;
  localparam logic [3:0] S_FMETA = 4'd10;
  localparam logic [3:0] S_FLAT  = 4'd11;
  localparam logic [3:0] S_FCHK  = 4'd12;
  localparam logic [3:0] S_FADV  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // memories
  meta_t       meta_mem [SETS];
  logic [31:0] data_mem [SETS*WAYS*WPL];
  logic [31:0] back_mem [MEM_WORDS];

  logic             meta_we;
  logic [SET_W-1:0] meta_waddr, meta_raddr;
  meta_t            meta_wdata, meta_rdata;
  logic             data_we;
  logic [DA_W-1:0]  data_waddr, data_raddr;
  logic [31:0]      data_wdata, data_rdata;
  logic [3:0]       data_be;
  logic             mem_we;
  logic [MA_W-1:0]  mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata, mem_rdata;
  logic [3:0]       mem_be;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      for (int b = 0; b < 4; b++) begin
        if (data_be[b]) data_mem[data_waddr][8*b +: 8] <= data_wdata[8*b +: 8];
      end
    end
    data_rdata <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (mem_be[b]) back_mem[mem_waddr][8*b +: 8] <= mem_wdata[8*b +: 8];
      end
    end
    mem_rdata <= back_mem[mem_raddr];
  end

  // registers
  logic [3:0]           state;
  logic [MA_W-1:0]      clr_cnt;
  logic [CNT_W-1:0]     cnt;
  logic                 repl_mode;
  logic [31:0]          stamp_counter;
  logic [2:0]           req_action;
  logic [ADDR_BITS-1:0] req_addr;
  logic [31:0]          req_wdata;
  logic [2:0]           req_size;
  logic [SET_W-1:0]     cur_set;
  logic [1:0]           cur_way;
  logic                 hit_q, wb_q;
  meta_t                meta_q;
  logic [31:0]          d0;
  logic [31:0]          res_data;
  logic                 res_hit, res_wb;
  logic [1:0]           res_way, res_status;

  function automatic logic [DA_W-1:0] da(input logic [SET_W-1:0] s, input logic [1:0] w,
                                         input logic [WI_W-1:0] i);
    return DA_W'((int'(s) * WAYS + int'(w)) * WPL + int'(i));
  endfunction

  function automatic logic [MA_W-1:0] la(input logic [TAG_W-1:0] t, input logic [SET_W-1:0] s,
                                         input logic [WI_W-1:0] i);
    return MA_W'((int'(t) * SETS + int'(s)) * WPL + int'(i));
  endfunction

  // address split of the held request and of the incoming one
  logic [OFF_W-1:0] r_off, in_off;
  logic [SET_W-1:0] r_set, in_set;
  logic [TAG_W-1:0] r_tag;
  logic [WI_W-1:0]  r_w0;
  logic [1:0]       r_b;
  logic             r_span, r_is_write, in_bad_size, in_cross, accept;
  logic [31:0]      r_mask;
  logic [7:0]       r_be64;
  logic [63:0]      r_wd64, r_win;
  logic [31:0]      acc_result;

  assign r_off  = OFF_W'(req_addr % LINE_BYTES);
  assign r_set  = SET_W'((req_addr / LINE_BYTES) % SETS);
  assign r_tag  = TAG_W'(req_addr / (LINE_BYTES * SETS));
  assign r_w0   = WI_W'(r_off / 4);
  assign r_b    = req_addr[1:0];
  assign r_span = (int'(r_b) + int'(req_size)) > 4;
  assign r_is_write = (req_action == ACT_WRITE);
  assign in_off = OFF_W'(address % LINE_BYTES);
  assign in_set = SET_W'((address / LINE_BYTES) % SETS);
  assign in_bad_size = !(size_bytes == 3'd1 || size_bytes == 3'd2 || size_bytes == 3'd4);
  assign in_cross = (int'(in_off) + int'(size_bytes)) > LINE_BYTES;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (req_size)
      3'd1:    begin r_mask = 32'h0000_00FF; r_be64 = 8'(4'b0001 << r_b); end
      3'd2:    begin r_mask = 32'h0000_FFFF; r_be64 = 8'(4'b0011 << r_b); end
      default: begin r_mask = 32'hFFFF_FFFF; r_be64 = 8'(4'b1111 << r_b); end
    endcase
  end

  assign r_wd64 = {32'b0, req_wdata & r_mask} << (8 * r_b);
  assign r_win  = {data_rdata, d0} >> (8 * r_b);
  assign acc_result = r_is_write ? (req_wdata & r_mask) : (r_win[31:0] & r_mask);

  // lookup and victim choice on the freshly read set
  logic       hv, inv_any;
  logic [1:0] hw, inv_w, lru_w, plru_w, vict_w;
  always_comb begin
    hv = 1'b0;
    hw = 2'd0;
    inv_any = 1'b0;
    inv_w = 2'd0;
    lru_w = 2'd0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (meta_rdata.valid[w] && meta_rdata.tag[w] == r_tag) begin
        hv = 1'b1;
        hw = 2'(w);
      end
      if (!meta_rdata.valid[w]) begin
        inv_any = 1'b1;
        inv_w = 2'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (meta_rdata.stamp[w] < meta_rdata.stamp[lru_w]) lru_w = 2'(w);
    end
    if (!meta_rdata.tree[0]) plru_w = meta_rdata.tree[1] ? 2'd1 : 2'd0;
    else                     plru_w = meta_rdata.tree[2] ? 2'd3 : 2'd2;
    vict_w = inv_any ? inv_w : (repl_mode ? lru_w : plru_w);
  end

  // tag entry after the access
  meta_t mnew;
  always_comb begin
    mnew = meta_q;
    if (!hit_q) begin
      mnew.valid[cur_way] = 1'b1;
      mnew.dirty[cur_way] = 1'b0;
      mnew.tag[cur_way]   = r_tag;
    end
    if (repl_mode) begin
      mnew.stamp[cur_way] = stamp_counter + 32'd1;
    end else if (!cur_way[1]) begin
      mnew.tree[0] = 1'b1;
      mnew.tree[1] = (cur_way == 2'd0);
    end else begin
      mnew.tree[0] = 1'b0;
      mnew.tree[2] = (cur_way == 2'd2);
    end
    if (r_is_write) mnew.dirty[cur_way] = 1'b1;
  end

  // memory ports
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = cur_set;
    meta_wdata = mnew;
    meta_raddr = cur_set;
    data_we    = 1'b0;
    data_waddr = da(cur_set, cur_way, r_w0);
    data_wdata = r_wd64[31:0];
    data_be    = r_be64[3:0];
    data_raddr = da(cur_set, cur_way, WI_W'(cnt));
    mem_we     = 1'b0;
    mem_waddr  = la(meta_q.tag[cur_way], cur_set, WI_W'(cnt - CNT_W'(1)));
    mem_wdata  = data_rdata;
    mem_be     = 4'hF;
    mem_raddr  = la(r_tag, cur_set, WI_W'(cnt));
    unique case (state)
      S_CLR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_cnt;
        mem_wdata  = '0;
        meta_we    = int'(clr_cnt) < SETS;
        meta_waddr = SET_W'(clr_cnt);
        meta_wdata = '0;
      end
      S_IDLE: begin
        meta_raddr = in_set;
        mem_raddr  = MA_W'(address >> 2);
        if (accept && action == ACT_PRELOAD) begin
          mem_we    = 1'b1;
          mem_waddr = MA_W'(address >> 2);
          mem_be    = 4'(4'b0001 << address[1:0]);
          mem_wdata = {4{store_data[7:0]}};
        end
      end
      S_WB: begin
        mem_we = (cnt != '0);
      end
      S_FILL: begin
        data_we    = (cnt != '0);
        data_waddr = da(cur_set, cur_way, WI_W'(cnt - CNT_W'(1)));
        data_wdata = mem_rdata;
        data_be    = 4'hF;
      end
      S_RD0: data_raddr = da(cur_set, cur_way, r_w0);
      S_RD1: data_raddr = da(cur_set, cur_way, r_w0 + WI_W'(1));
      S_WR: begin
        data_we = r_is_write;
        meta_we = 1'b1;
      end
      S_WR1: begin
        data_we    = 1'b1;
        data_waddr = da(cur_set, cur_way, r_w0 + WI_W'(1));
        data_wdata = r_wd64[63:32];
        data_be    = r_be64[7:4];
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_cnt       <= '0;
      out_valid     <= 1'b0;
      stamp_counter <= '0;
      repl_mode     <= 1'b1;
    end else begin
      if (cfg_write_en) repl_mode <= cfg_data;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + MA_W'(1);
          if (clr_cnt == MA_W'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_action <= action;
            req_addr   <= address;
            req_wdata  <= store_data;
            req_size   <= size_bytes;
            res_data   <= '0;
            res_hit    <= 1'b0;
            res_way    <= 2'd0;
            res_wb     <= 1'b0;
            res_status <= ST_OK;
            hit_q      <= 1'b0;
            wb_q       <= 1'b0;
            case (action)
              ACT_READ, ACT_WRITE: begin
                if (in_bad_size) begin
                  res_status <= ST_SIZE;
                  state      <= S_DONE;
                end else if (in_cross) begin
                  res_status <= ST_CROSS;
                  state      <= S_DONE;
                end else begin
                  cur_set <= in_set;
                  state   <= S_LOOK;
                end
              end
              ACT_PRELOAD: begin
                res_data <= {24'b0, store_data[7:0]};
                state    <= S_DONE;
              end
              ACT_READBACK: state <= S_RBK;
              ACT_FLUSH: begin
                cur_set <= '0;
                state   <= S_FMETA;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RBK: begin
          res_data <= 32'(mem_rdata >> (8 * req_addr[1:0])) & 32'h0000_00FF;
          state    <= S_DONE;
        end
        S_LOOK: begin
          meta_q <= meta_rdata;
          cnt    <= '0;
          if (hv) begin
            cur_way <= hw;
            hit_q   <= 1'b1;
            state   <= S_RD0;
          end else begin
            cur_way <= vict_w;
            if (meta_rdata.valid[vict_w] && meta_rdata.dirty[vict_w]) begin
              wb_q  <= 1'b1;
              state <= S_WB;
            end else begin
              state <= S_FILL;
            end
          end
        end
        S_WB: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(WPL)) begin
            cnt   <= '0;
            state <= (req_action == ACT_FLUSH) ? S_FADV : S_FILL;
          end
        end
        S_FILL: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(WPL)) state <= S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          d0    <= data_rdata;
          state <= S_WR;
        end
        S_WR: begin
          res_data <= acc_result;
          res_hit  <= hit_q;
          res_way  <= cur_way;
          res_wb   <= wb_q;
          if (repl_mode) stamp_counter <= stamp_counter + 32'd1;
          state <= (r_is_write && r_span) ? S_WR1 : S_DONE;
        end
        S_WR1: state <= S_DONE;
        S_FMETA: state <= S_FLAT;
        S_FLAT: begin
          meta_q  <= meta_rdata;
          cur_way <= 2'd0;
          state   <= S_FCHK;
        end
        S_FCHK: begin
          cnt <= '0;
          state <= (meta_q.valid[cur_way] && meta_q.dirty[cur_way]) ? S_WB : S_FADV;
        end
        S_FADV: begin
          if (cur_way == 2'(WAYS - 1)) begin
            if (cur_set == SET_W'(SETS - 1)) begin
              state <= S_DONE;
            end else begin
              cur_set <= cur_set + SET_W'(1);
              state   <= S_FMETA;
            end
          end else begin
            cur_way <= cur_way + 2'd1;
            state   <= S_FCHK;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            read_data  <= res_data;
            hit        <= res_hit;
            result_way <= res_way;
            wrote_back <= res_wb;
            status     <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/sacl_chk.sv @@
// Port-level checks for the cache top level, bound onto it below.
// Depends on sacl_pkg and set_assoc_cache_lru_plru_top.
module sacl_chk import sacl_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [31:0]          read_data,
  input logic                 hit,
  input logic                 wrote_back,
  input logic [1:0]           status
);

  // one request in flight: ready drops right after a request is taken
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
    else $error("stalled result changed");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !hit && !wrote_back && read_data == 32'd0)
    else $error("rejected request reported data");

  a_wb_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && wrote_back |-> !hit)
    else $error("write-back reported on a hit");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind set_assoc_cache_lru_plru_top sacl_chk u_sacl_chk (.*);
